FILE: sv/bitmap_page_frame_allocator_macros.svh
// Assertion macros used by the checker file of the page frame allocator.
// Needs clk_i and rst_ni in the scope of every use.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BPFA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bpfa assertion failed");

// Next-cycle implication, disabled while in reset.
`define BPFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bpfa assertion failed");

`endif

FILE: sv/bpfa_pkg.sv
// Package of the bitmap page frame allocator: widths, opcodes, FSM states
// and the structs passed between the top level and the word modify unit.
package bpfa_pkg;

  localparam int unsigned FRAMES_DEF     = 4096;
  localparam int unsigned PAGE_SHIFT_DEF = 12;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_W     = 5;
  localparam int unsigned FLIP_W    = 6;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned FREE_W  = 13;
  // wide enough for byte offsets up to FRAMES << PAGE_SHIFT plus rounding
  localparam int unsigned EXT_W   = 40;

  localparam int unsigned IN_W  = 72;
  localparam int unsigned OUT_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_RESERVE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FREE_CHK,
    ST_RANGE_END,
    ST_RANGE_BND,
    ST_SETUP,
    ST_WALK,
    ST_OUT
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [BIT_W-1:0] lo_bit;
    logic [BIT_W-1:0] hi_bit;
  } word_ctl_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] new_word;
    logic [FLIP_W-1:0]    flips;
    logic                 found;
    logic [BIT_W-1:0]     bit_idx;
  } word_res_t;

endpackage

FILE: sv/bitmap_page_frame_allocator.sv
// Bitmap first-fit page frame allocator, top level.
// Uses bpfa_pkg, bpfa_ram (bitmap store) and bpfa_word_op (word modify).
//
// Input stream s_axis carries one request per transfer: operation (allocate,
// free one frame, release range, reserve range), a byte address and a byte
// length. Output stream m_axis carries one result per request: the allocated
// frame's byte address, a success flag and the free-frame count afterwards.
// The bitmap (one bit per frame, 1 = used) lives in a RAM of ceil(FRAMES/32)
// words with registered read data; each request walks the words it touches,
// reading one word per cycle and writing the modified word back in the next.
// The words visited are 1 for free, the words a range covers, and up to
// ceil(FRAMES/32) (128 by default) for an allocation, which stops at the
// first word with a clear bit. Refused or empty requests visit no words.
// One request is handled at a time; s_axis_tready is high only while idle.
// After reset a clearing pass marks every frame used, one word per cycle,
// with s_axis_tready low; the free count resets to 0.
// Results sit in an output register; a stalled receiver holds the result and
// the block takes one more request, then waits with it finished until the
// output register empties.
module bitmap_page_frame_allocator #(
  parameter int unsigned FRAMES     = bpfa_pkg::FRAMES_DEF,
  parameter int unsigned PAGE_SHIFT = bpfa_pkg::PAGE_SHIFT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [1:0] operation, [33:2] address, [65:34] length, [71:66] zero
  input  logic [bpfa_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [31:0] frame_address, [32] success, [45:33] free_frames, [47:46] zero
  output logic [bpfa_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int unsigned WORDS = (FRAMES + bpfa_pkg::WORD_BITS - 1) / bpfa_pkg::WORD_BITS;
  localparam int unsigned WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned FI_W  = $clog2(FRAMES + 1);
  localparam int unsigned CNT_W = $clog2(FRAMES + 1);
  localparam int unsigned EW    = bpfa_pkg::EXT_W;

  localparam logic [EW-1:0]   MANAGED    = EW'(FRAMES) << PAGE_SHIFT;
  localparam logic [EW-1:0]   PAGE_BYTES = EW'(1) << PAGE_SHIFT;
  localparam logic [EW-1:0]   FRAMES_EXT = EW'(FRAMES);
  localparam logic [WA_W-1:0] LAST_WORD  = WA_W'(WORDS - 1);

  bpfa_pkg::state_e state_q, state_d;
  bpfa_pkg::op_e    op_q, op_d;

  logic [bpfa_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic [bpfa_pkg::LEN_W-1:0]  len_q, len_d;
  logic [EW-1:0]               end_q, end_d;
  logic [FI_W-1:0]             first_q, first_d;
  logic [FI_W-1:0]             last_q, last_d;
  logic [WA_W-1:0]             lo_w_q, lo_w_d;
  logic [WA_W-1:0]             hi_w_q, hi_w_d;
  logic [bpfa_pkg::BIT_W-1:0]  lo_bit_q, lo_bit_d;
  logic [bpfa_pkg::BIT_W-1:0]  hi_bit_q, hi_bit_d;
  logic [WA_W-1:0]             cur_w_q, cur_w_d;
  logic [WA_W-1:0]             proc_w_q, proc_w_d;
  logic                        issued_q, issued_d;
  logic                        rd_pend_q, rd_pend_d;
  logic [WA_W-1:0]             clr_q, clr_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic                        ok_q, ok_d;
  logic [bpfa_pkg::ADDR_W-1:0] fa_q, fa_d;

  logic                        m_valid_q, m_valid_d;
  logic [bpfa_pkg::OUT_W-1:0]  m_data_q, m_data_d;

  logic                          ram_we;
  logic [WA_W-1:0]               ram_waddr;
  logic [bpfa_pkg::WORD_BITS-1:0] ram_wdata;
  logic [bpfa_pkg::WORD_BITS-1:0] ram_rdata;

  bpfa_pkg::word_ctl_t wctl;
  bpfa_pkg::word_res_t wres;

  logic [EW-1:0] addr_ext;
  logic [EW-1:0] sum_ext;
  logic [EW-1:0] first_ext;
  logic [EW-1:0] last_ext;
  logic [FI_W-1:0] last_m1;
  logic [FI_W-1:0] alloc_frame;

  bpfa_ram #(
    .WIDTH (bpfa_pkg::WORD_BITS),
    .DEPTH (WORDS),
    .AW    (WA_W)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cur_w_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    wctl.op     = op_q;
    wctl.lo_bit = (proc_w_q == lo_w_q) ? lo_bit_q : '0;
    wctl.hi_bit = (proc_w_q == hi_w_q) ? hi_bit_q : '1;
  end

  bpfa_word_op u_word_op (
    .rd_word_i (ram_rdata),
    .ctl_i     (wctl),
    .res_o     (wres)
  );

  assign addr_ext    = EW'(addr_q);
  assign sum_ext     = addr_ext + EW'(len_q);
  assign first_ext   = (op_q == bpfa_pkg::OP_RELEASE) ?
                       ((addr_ext + PAGE_BYTES - EW'(1)) >> PAGE_SHIFT) :
                       (addr_ext >> PAGE_SHIFT);
  assign last_ext    = (op_q == bpfa_pkg::OP_RELEASE) ?
                       (end_q >> PAGE_SHIFT) :
                       ((end_q + PAGE_BYTES - EW'(1)) >> PAGE_SHIFT);
  assign last_m1     = last_q - FI_W'(1);
  assign alloc_frame = FI_W'({proc_w_q, wres.bit_idx});

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    addr_d    = addr_q;
    len_d     = len_q;
    end_d     = end_q;
    first_d   = first_q;
    last_d    = last_q;
    lo_w_d    = lo_w_q;
    hi_w_d    = hi_w_q;
    lo_bit_d  = lo_bit_q;
    hi_bit_d  = hi_bit_q;
    cur_w_d   = cur_w_q;
    proc_w_d  = proc_w_q;
    issued_d  = issued_q;
    rd_pend_d = 1'b0;
    clr_d     = clr_q;
    count_d   = count_q;
    ok_d      = ok_q;
    fa_d      = fa_q;
    ram_we    = 1'b0;
    ram_waddr = proc_w_q;
    ram_wdata = wres.new_word;
    s_axis_tready = 1'b0;

    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;

    unique case (state_q)
      bpfa_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '1;
        clr_d     = clr_q + WA_W'(1);
        if (clr_q == LAST_WORD) begin
          state_d = bpfa_pkg::ST_IDLE;
        end
      end

      bpfa_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d   = bpfa_pkg::op_e'(s_axis_tdata[1:0]);
          addr_d = s_axis_tdata[33:2];
          len_d  = s_axis_tdata[65:34];
          fa_d   = '0;
          unique case (bpfa_pkg::op_e'(s_axis_tdata[1:0]))
            bpfa_pkg::OP_ALLOC: begin
              ok_d    = 1'b0;
              first_d = '0;
              last_d  = FI_W'(FRAMES);
              state_d = bpfa_pkg::ST_SETUP;
            end
            bpfa_pkg::OP_FREE: begin
              ok_d    = 1'b0;
              state_d = bpfa_pkg::ST_FREE_CHK;
            end
            default: begin
              ok_d    = 1'b1;
              state_d = bpfa_pkg::ST_RANGE_END;
            end
          endcase
        end
      end

      bpfa_pkg::ST_FREE_CHK: begin
        if (((addr_ext & (PAGE_BYTES - EW'(1))) != '0) ||
            ((addr_ext >> PAGE_SHIFT) >= FRAMES_EXT)) begin
          state_d = bpfa_pkg::ST_OUT;
        end else begin
          first_d = FI_W'(addr_ext >> PAGE_SHIFT);
          last_d  = FI_W'(addr_ext >> PAGE_SHIFT) + FI_W'(1);
          state_d = bpfa_pkg::ST_SETUP;
        end
      end

      bpfa_pkg::ST_RANGE_END: begin
        if (addr_ext >= MANAGED) begin
          state_d = bpfa_pkg::ST_OUT;
        end else begin
          end_d   = (sum_ext > MANAGED) ? MANAGED : sum_ext;
          state_d = bpfa_pkg::ST_RANGE_BND;
        end
      end

      bpfa_pkg::ST_RANGE_BND: begin
        first_d = FI_W'(first_ext);
        last_d  = (last_ext > FRAMES_EXT) ? FI_W'(FRAMES) : FI_W'(last_ext);
        state_d = bpfa_pkg::ST_SETUP;
      end

      bpfa_pkg::ST_SETUP: begin
        if (first_q >= last_q) begin
          state_d = bpfa_pkg::ST_OUT;
        end else begin
          lo_w_d   = WA_W'(first_q >> bpfa_pkg::BIT_W);
          hi_w_d   = WA_W'(last_m1 >> bpfa_pkg::BIT_W);
          lo_bit_d = first_q[bpfa_pkg::BIT_W-1:0];
          hi_bit_d = last_m1[bpfa_pkg::BIT_W-1:0];
          cur_w_d  = WA_W'(first_q >> bpfa_pkg::BIT_W);
          issued_d = 1'b0;
          state_d  = bpfa_pkg::ST_WALK;
        end
      end

      bpfa_pkg::ST_WALK: begin
        // issue the next read while the previous word is modified
        if (!issued_q) begin
          rd_pend_d = 1'b1;
          proc_w_d  = cur_w_q;
          cur_w_d   = cur_w_q + WA_W'(1);
          issued_d  = (cur_w_q == hi_w_q);
        end
        if (rd_pend_q) begin
          ram_we = 1'b1;
          if (op_q == bpfa_pkg::OP_RELEASE || op_q == bpfa_pkg::OP_FREE) begin
            count_d = count_q + CNT_W'(wres.flips);
          end else begin
            count_d = count_q - CNT_W'(wres.flips);
          end
          if (op_q == bpfa_pkg::OP_FREE) begin
            ok_d = (wres.flips != '0);
          end
          if (op_q == bpfa_pkg::OP_ALLOC && wres.found) begin
            ok_d    = 1'b1;
            fa_d    = bpfa_pkg::ADDR_W'(EW'(alloc_frame) << PAGE_SHIFT);
            state_d = bpfa_pkg::ST_OUT;
          end else if (proc_w_q == hi_w_q) begin
            state_d = bpfa_pkg::ST_OUT;
          end
        end
      end

      bpfa_pkg::ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {2'b00, bpfa_pkg::FREE_W'(count_q), ok_q, fa_q};
          state_d   = bpfa_pkg::ST_IDLE;
        end
      end

      default: state_d = bpfa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bpfa_pkg::ST_CLEAR;
      clr_q     <= '0;
      count_q   <= '0;
      rd_pend_q <= 1'b0;
      issued_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      count_q   <= count_d;
      rd_pend_q <= rd_pend_d;
      issued_q  <= issued_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    addr_q   <= addr_d;
    len_q    <= len_d;
    end_q    <= end_d;
    first_q  <= first_d;
    last_q   <= last_d;
    lo_w_q   <= lo_w_d;
    hi_w_q   <= hi_w_d;
    lo_bit_q <= lo_bit_d;
    hi_bit_q <= hi_bit_d;
    cur_w_q  <= cur_w_d;
    proc_w_q <= proc_w_d;
    ok_q     <= ok_d;
    fa_q     <= fa_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

FILE: sv/bpfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bpfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: sv/bpfa_word_op.sv
// Read-modify unit for one 32-bit bitmap word: lowest-free search for
// allocation, range mask set/clear, and the count of flipped bits. Uses bpfa_pkg.
module bpfa_word_op (
  input  logic [bpfa_pkg::WORD_BITS-1:0] rd_word_i,
  input  bpfa_pkg::word_ctl_t            ctl_i,
  output bpfa_pkg::word_res_t            res_o
);

  localparam logic [bpfa_pkg::WORD_BITS-1:0] ONES = '1;

  logic [bpfa_pkg::WORD_BITS-1:0] range_mask;
  logic [bpfa_pkg::WORD_BITS-1:0] low_zero;
  logic [bpfa_pkg::WORD_BITS-1:0] new_word;
  logic [bpfa_pkg::WORD_BITS-1:0] diff;
  logic [bpfa_pkg::BIT_W-1:0]     idx;
  logic [bpfa_pkg::FLIP_W-1:0]    cnt;

  assign range_mask = (ONES << ctl_i.lo_bit) & (ONES >> (5'd31 - ctl_i.hi_bit));
  // one-hot of the lowest clear bit
  assign low_zero   = ~rd_word_i & (rd_word_i + 32'd1);

  always_comb begin
    idx = '0;
    for (int i = 0; i < bpfa_pkg::WORD_BITS; i++) begin
      if (low_zero[i]) begin
        idx = idx | bpfa_pkg::BIT_W'(i);
      end
    end
  end

  always_comb begin
    unique case (ctl_i.op) inside
      bpfa_pkg::OP_ALLOC:                       new_word = rd_word_i | low_zero;
      bpfa_pkg::OP_RESERVE:                     new_word = rd_word_i | range_mask;
      bpfa_pkg::OP_FREE, bpfa_pkg::OP_RELEASE:  new_word = rd_word_i & ~range_mask;
      default:                                  new_word = rd_word_i;
    endcase
  end

  assign diff = rd_word_i ^ new_word;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < bpfa_pkg::WORD_BITS; i++) begin
      cnt = cnt + bpfa_pkg::FLIP_W'(diff[i]);
    end
  end

  always_comb begin
    res_o.new_word = new_word;
    res_o.flips    = cnt;
    res_o.found    = |low_zero;
    res_o.bit_idx  = idx;
  end

endmodule

FILE: sv/bpfa_checker.sv
// Port-level checker for the page frame allocator, bound to the top level.
// Uses bpfa_pkg and the assertion macros header.
`include "bitmap_page_frame_allocator_macros.svh"

module bpfa_checker #(
  parameter int unsigned PAGE_SHIFT = bpfa_pkg::PAGE_SHIFT_DEF
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [bpfa_pkg::OUT_W-1:0] m_axis_tdata
);

  // a held result must not change under the receiver
  `BPFA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // one request at a time: ready drops right after an input transfer
  `BPFA_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // unsuccessful results carry a zero address
  `BPFA_ASSERT_SAME(a_fail_zero_addr, m_axis_tvalid && !m_axis_tdata[32],
                    m_axis_tdata[31:0] == 32'd0)

  // every frame address is page aligned
  `BPFA_ASSERT_SAME(a_addr_aligned, m_axis_tvalid,
                    m_axis_tdata[PAGE_SHIFT-1:0] == '0)

endmodule

bind bitmap_page_frame_allocator bpfa_checker #(
  .PAGE_SHIFT (PAGE_SHIFT)
) u_bpfa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
